// File: rtl/core/adj_pkg.sv
// ----------------------------------------------------------------------------
// adj_pkg
// Shared widths, codes and types of the pair list to adjacency table block.
// ----------------------------------------------------------------------------
package adj_pkg;

  localparam int ID_W       = 10;  // node id
  localparam int SLOT_W     = 3;   // slot index of a read
  localparam int KIND_W     = 2;
  localparam int STAT_W     = 2;
  localparam int NC_W       = 11;  // node_count register
  localparam int SC_W       = 4;   // slots_per_node register
  localparam int VAL_W      = 11;  // signed entry value
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_W      = 11;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam logic [VAL_W-1:0] EMPTY_VAL = '1;  // -1

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_PER_NODE = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,   // fill count sweep after reset
    S_IDLE,
    S_CLR,    // fill count sweep for a clear word
    S_FA,     // read fill count of first id
    S_FB,     // check first id, read fill count of second id
    S_FC,     // check second id
    S_WA,     // append to first id's list
    S_WB,     // append to second id's list
    S_RA,     // read fill count and slot
    S_RB,     // form read result
    S_PUSH    // load output register
  } state_t;

  typedef struct packed {
    status_t           status;
    logic [VAL_W-1:0]  value;
  } resp_t;

  typedef struct packed {
    kind_t              kind;
    logic [ID_W-1:0]    first_id;
    logic [ID_W-1:0]    second_id;
    logic [SLOT_W-1:0]  slot_index;
  } cmd_t;

endpackage

// File: rtl/core/pair_list_to_adjacency_table.sv
// ----------------------------------------------------------------------------
// pair_list_to_adjacency_table
// Fixed-width adjacency table built from undirected pairs, with clear,
// insert and slot read words, one result word per input word.
// An insert checks the first id's fill count, then the second's, then
// appends to both lists (one for a self pair); a full list ends it early.
// Bad ids, ignored inserts and unused kinds go straight to the result. The
// next word is taken once the result is loaded into the free result register.
// Insert steps are two fill count read-modify-writes through the shared
// list unit and the single RAM ports. Reset (synchronous) starts a sweep
// zeroing the fill counts; no word is accepted then, config writes are taken.
// ----------------------------------------------------------------------------
module pair_list_to_adjacency_table import adj_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_SLOTS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // first_id, second_id, slot_index
  input  logic [KIND_W-1:0]     s_tuser,   // kind
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // entry_value
  output logic [STAT_W-1:0]     m_tuser    // status
);

  localparam int FW    = $clog2(MAX_NODES);
  localparam int AW    = $clog2(MAX_NODES * MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  cmd_t             in_cmd;
  resp_t            out_resp;
  logic             fill_we;
  logic [FW-1:0]    fill_waddr;
  logic [CNT_W-1:0] fill_wdata;
  logic [FW-1:0]    fill_raddr;
  logic [CNT_W-1:0] fill_rdata;
  logic             store_we;
  logic [ID_W-1:0]  store_wdata;
  logic [ID_W-1:0]  store_rdata;
  logic [ID_W-1:0]  unit_node;
  logic [CNT_W-1:0] unit_count;
  logic [SC_W-1:0]  unit_cap;
  logic             unit_full;
  logic [CNT_W-1:0] unit_inc;
  logic [AW-1:0]    unit_addr;

  assign in_cmd.kind       = kind_t'(s_tuser);
  assign in_cmd.first_id   = s_tdata[ID_W-1:0];
  assign in_cmd.second_id  = s_tdata[2*ID_W-1:ID_W];
  assign in_cmd.slot_index = s_tdata[2*ID_W+SLOT_W-1:2*ID_W];

  assign m_tdata = OUT_DATA_W'(out_resp.value);
  assign m_tuser = out_resp.status;

  adj_ctrl #(
    .MAX_NODES (MAX_NODES),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_cmd      (in_cmd),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_resp    (out_resp),
    .fill_we     (fill_we),
    .fill_waddr  (fill_waddr),
    .fill_wdata  (fill_wdata),
    .fill_raddr  (fill_raddr),
    .fill_rdata  (fill_rdata),
    .store_we    (store_we),
    .store_wdata (store_wdata),
    .store_rdata (store_rdata),
    .unit_node   (unit_node),
    .unit_count  (unit_count),
    .unit_cap    (unit_cap),
    .unit_full   (unit_full),
    .unit_inc    (unit_inc)
  );

  adj_unit #(
    .MAX_NODES (MAX_NODES),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_unit (
    .node      (unit_node),
    .count     (unit_count),
    .cap       (unit_cap),
    .full      (unit_full),
    .count_inc (unit_inc),
    .addr      (unit_addr)
  );

  adj_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_NODES)
  ) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (fill_raddr),
    .rdata (fill_rdata)
  );

  adj_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_NODES * MAX_SLOTS)
  ) u_store_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (unit_addr),
    .wdata (store_wdata),
    .raddr (unit_addr),
    .rdata (store_rdata)
  );

endmodule

// File: rtl/core/adj_ram.sv
// ----------------------------------------------------------------------------
// adj_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module adj_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 8192,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/adj_unit.sv
// ----------------------------------------------------------------------------
// adj_unit
// Shared list unit: capacity compare, count increment and store address.
// ----------------------------------------------------------------------------
module adj_unit import adj_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_SLOTS = 8,
  localparam int AW       = $clog2(MAX_NODES * MAX_SLOTS),
  localparam int CNT_W    = $clog2(MAX_SLOTS + 1)
) (
  input  logic [ID_W-1:0]  node,
  input  logic [CNT_W-1:0] count,
  input  logic [SC_W-1:0]  cap,
  output logic             full,
  output logic [CNT_W-1:0] count_inc,
  output logic [AW-1:0]    addr
);

  localparam int CMP_W = (CNT_W > SC_W) ? CNT_W : SC_W;
  localparam int PW    = ID_W + CNT_W;

  logic [PW-1:0] prod;

  assign full      = CMP_W'(count) >= CMP_W'(cap);
  assign count_inc = count + 1'b1;
  // row base plus position; constant multiplier
  assign prod      = PW'(node) * PW'(MAX_SLOTS) + PW'(count);
  assign addr      = AW'(prod);

endmodule

// File: rtl/core/adj_ctrl.sv
// ----------------------------------------------------------------------------
// adj_ctrl
// Sequencer: config registers, error latch, fill count sweep, insert and
// read steps, output register.
// ----------------------------------------------------------------------------
module adj_ctrl import adj_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_SLOTS = 8,
  localparam int FW       = $clog2(MAX_NODES),
  localparam int CNT_W    = $clog2(MAX_SLOTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cmd_t                 in_cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output resp_t                out_resp,
  output logic                 fill_we,
  output logic [FW-1:0]        fill_waddr,
  output logic [CNT_W-1:0]     fill_wdata,
  output logic [FW-1:0]        fill_raddr,
  input  logic [CNT_W-1:0]     fill_rdata,
  output logic                 store_we,
  output logic [ID_W-1:0]      store_wdata,
  input  logic [ID_W-1:0]      store_rdata,
  output logic [ID_W-1:0]      unit_node,
  output logic [CNT_W-1:0]     unit_count,
  output logic [SC_W-1:0]      unit_cap,
  input  logic                 unit_full,
  input  logic [CNT_W-1:0]     unit_inc
);

  localparam int CMP_A    = (CNT_W > SC_W) ? CNT_W : SC_W;
  localparam int CMP_W    = (CMP_A > SLOT_W) ? CMP_A : SLOT_W;
  localparam int NODE_RST = (MAX_NODES < 1024) ? MAX_NODES : 1024;
  localparam int SLOT_RST = (MAX_SLOTS < 8) ? MAX_SLOTS : 8;
  localparam logic [FW-1:0] LAST_NODE = FW'(MAX_NODES - 1);

  state_t            state;
  state_t            state_next;
  cmd_t              cmd;
  resp_t             res;
  logic              err;
  logic [NC_W-1:0]   node_lim;
  logic [SC_W-1:0]   slot_cap;
  logic [FW-1:0]     clr_idx;
  logic [CNT_W-1:0]  cnt_a;
  logic [CNT_W-1:0]  cnt_b;

  logic              in_a_ok;
  logic              in_b_ok;
  logic              rd_hit;
  logic              sweep_last;
  logic              out_free;
  logic [NC_W-1:0]   node_sat;
  logic [SC_W-1:0]   slot_sat;
  status_t           in_status;

  // saturate register writes to the built capacity
  assign node_sat = (int'(cfg_wdata) > MAX_NODES) ? NC_W'(MAX_NODES) : cfg_wdata;
  assign slot_sat = (int'(cfg_wdata[SC_W-1:0]) > MAX_SLOTS) ? SC_W'(MAX_SLOTS)
                                                            : cfg_wdata[SC_W-1:0];

  assign in_a_ok    = {1'b0, in_cmd.first_id} < node_lim;
  assign in_b_ok    = {1'b0, in_cmd.second_id} < node_lim;
  assign rd_hit     = (CMP_W'(cmd.slot_index) < CMP_W'(slot_cap)) &&
                      (CMP_W'(cmd.slot_index) < CMP_W'(fill_rdata));
  assign sweep_last = clr_idx == LAST_NODE;
  assign out_free   = !out_valid || out_ready;
  assign unit_cap   = slot_cap;

  // status known at accept time
  always_comb begin
    in_status = ST_OK;
    case (in_cmd.kind)
      KIND_INSERT: begin
        if (err) in_status = ST_IGNORED;
        else if (!in_a_ok || !in_b_ok) in_status = ST_RANGE;
      end
      KIND_READ: begin
        if (!in_a_ok) in_status = ST_RANGE;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_cmd.kind)
            KIND_CLEAR:  state_next = S_CLR;
            KIND_INSERT: state_next = (err || !in_a_ok || !in_b_ok) ? S_PUSH : S_FA;
            KIND_READ:   state_next = in_a_ok ? S_RA : S_PUSH;
            default:     state_next = S_PUSH;
          endcase
        end
      end
      S_CLR: begin
        if (sweep_last) state_next = S_PUSH;
      end
      S_FA:   state_next = S_FB;
      S_FB:   state_next = unit_full ? S_PUSH : S_FC;
      S_FC:   state_next = unit_full ? S_PUSH : S_WA;
      S_WA:   state_next = (cmd.first_id == cmd.second_id) ? S_PUSH : S_WB;
      S_WB:   state_next = S_PUSH;
      S_RA:   state_next = S_RB;
      S_RB:   state_next = S_PUSH;
      S_PUSH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  // memory and unit controls
  always_comb begin
    in_ready    = 1'b0;
    fill_we     = 1'b0;
    fill_waddr  = FW'(cmd.first_id);
    fill_wdata  = unit_inc;
    fill_raddr  = FW'(cmd.first_id);
    store_we    = 1'b0;
    store_wdata = cmd.second_id;
    unit_node   = cmd.first_id;
    unit_count  = fill_rdata;
    case (state)
      S_INIT, S_CLR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_idx;
        fill_wdata = '0;
      end
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_FB: begin
        fill_raddr = FW'(cmd.second_id);
      end
      S_FC: begin
        unit_node = cmd.second_id;
      end
      S_WA: begin
        unit_count = cnt_a;
        fill_we    = 1'b1;
        store_we   = 1'b1;
      end
      S_WB: begin
        unit_node   = cmd.second_id;
        unit_count  = cnt_b;
        fill_we     = 1'b1;
        fill_waddr  = FW'(cmd.second_id);
        store_we    = 1'b1;
        store_wdata = cmd.first_id;
      end
      S_RA: begin
        unit_count = CNT_W'(cmd.slot_index);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      err       <= 1'b0;
      clr_idx   <= '0;
      out_valid <= 1'b0;
      node_lim  <= NC_W'(NODE_RST);
      slot_cap  <= SC_W'(SLOT_RST);
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_addr)
          REG_NODE_COUNT:     node_lim <= node_sat;
          REG_SLOTS_PER_NODE: slot_cap <= slot_sat;
          default: ;
        endcase
      end
      if (state == S_PUSH && out_free) begin
        out_valid <= 1'b1;
        out_resp  <= res;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT, S_CLR: begin
          clr_idx <= sweep_last ? '0 : clr_idx + 1'b1;
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd        <= in_cmd;
            res.status <= in_status;
            res.value  <= EMPTY_VAL;
            case (in_cmd.kind)
              KIND_CLEAR: err <= 1'b0;
              KIND_INSERT: begin
                if (!err && (!in_a_ok || !in_b_ok)) err <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_FB: begin
          cnt_a <= fill_rdata;
          if (unit_full) begin
            res.status <= ST_FULL;
            err        <= 1'b1;
          end
        end
        S_FC: begin
          cnt_b <= fill_rdata;
          if (unit_full) begin
            res.status <= ST_FULL;
            err        <= 1'b1;
          end
        end
        S_RB: begin
          if (rd_hit) res.value <= {1'b0, store_rdata};
        end
        default: ;
      endcase
    end
  end

  // store is only written by an insert that has not failed
  assert property (@(posedge clk) disable iff (rst)
    store_we |-> (!err && cmd.kind == KIND_INSERT))
    else $error("store write outside a clean insert");

  // an append never takes a list past its capacity
  assert property (@(posedge clk) disable iff (rst)
    (fill_we && state != S_INIT && state != S_CLR)
      |-> CMP_W'(fill_wdata) <= CMP_W'(slot_cap))
    else $error("fill count beyond capacity");

  // any insert that did not succeed leaves the error latched
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && cmd.kind == KIND_INSERT && res.status != ST_OK) |-> err)
    else $error("failed insert without latched error");

  // only a read ever returns a neighbour id
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && cmd.kind != KIND_READ) |-> res.value == EMPTY_VAL)
    else $error("entry value on a non-read word");

  // reset always restarts the fill count sweep
  assert property (@(posedge clk) rst |=> (state == S_INIT && clr_idx == '0))
    else $error("reset did not start the sweep");

endmodule

// File: tb/sv/pair_list_to_adjacency_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_list_to_adjacency_table_tb
// Self-checking bench for the adjacency table builder. A shadow table
// predicts every result word. Directed words cover extremes and corner
// cases, then random phases with varied register settings follow. Both
// stream sides idle at random.
// ----------------------------------------------------------------------------
module pair_list_to_adjacency_table_tb import adj_pkg::*;;

  localparam int NODES          = 1024;
  localparam int SLOTS          = 8;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int N_PHASES       = 9;
  localparam int PHASE_WORDS    = 200;

  // kind 3 has no meaning; block must leave the table alone
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  class adj_table_shadow;
    int unsigned     fill [NODES];
    logic [ID_W-1:0] nbr [NODES][SLOTS];
    bit              err;
    int unsigned     node_cnt;
    int unsigned     slot_cnt;
    resp_t           awaited_resps[$];
    int              mismatches;

    function new();
      foreach (fill[i]) fill[i] = 0;
      err        = 1'b0;
      node_cnt   = 1024;
      slot_cnt   = 8;
      mismatches = 0;
    endfunction

    function int unsigned live_nodes();
      return (node_cnt > NODES) ? NODES : node_cnt;
    endfunction

    function int unsigned live_slots();
      return (slot_cnt > SLOTS) ? SLOTS : slot_cnt;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      if (idx == REG_NODE_COUNT) node_cnt = v;
      else slot_cnt = v[SC_W-1:0];
    endfunction

    // accepted input word -> expected result word
    function void note_word(logic [KIND_W-1:0] kind, logic [ID_W-1:0] a,
                            logic [ID_W-1:0] b, logic [SLOT_W-1:0] slot);
      resp_t r;
      r.status = ST_OK;
      r.value  = EMPTY_VAL;
      case (kind)
        KIND_CLEAR: begin
          foreach (fill[i]) fill[i] = 0;
          err = 1'b0;
        end
        KIND_INSERT: begin
          if (err) begin
            r.status = ST_IGNORED;
          end else if (a >= live_nodes() || b >= live_nodes()) begin
            r.status = ST_RANGE;
            err = 1'b1;
          end else if (fill[a] >= live_slots() || fill[b] >= live_slots()) begin
            r.status = ST_FULL;
            err = 1'b1;
          end else begin
            nbr[a][fill[a]] = b;
            fill[a]++;
            if (a != b) begin
              nbr[b][fill[b]] = a;
              fill[b]++;
            end
          end
        end
        KIND_READ: begin
          if (a >= live_nodes()) r.status = ST_RANGE;
          else if (slot < live_slots() && slot < fill[a]) r.value = {1'b0, nbr[a][slot]};
        end
        default: ;
      endcase
      awaited_resps.insert(awaited_resps.size(), r);
    endfunction

    function void check_resp(status_t st, logic [VAL_W-1:0] val);
      resp_t e;
      if (awaited_resps.size() == 0) begin
        $error("result word with nothing awaited: status %0d entry_value %0d",
               st, $signed(val));
        mismatches++;
        return;
      end
      e = awaited_resps.pop_front();
      if (st !== e.status) begin
        $error("status mismatch: expected %0d, actual %0d", e.status, st);
        mismatches++;
      end
      if (val !== e.value) begin
        $error("entry_value mismatch: expected %0d, actual %0d",
               $signed(e.value), $signed(val));
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // first_id, second_id, slot_index
  logic [KIND_W-1:0]     s_tuser;   // kind
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // entry_value
  logic [STAT_W-1:0]     m_tuser;   // status

  adj_table_shadow shadow;
  bit              src_steady;
  bit              sink_steady;
  int              quiet_cycles;

  pair_list_to_adjacency_table #(
    .MAX_NODES (NODES),
    .MAX_SLOTS (SLOTS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // called at a falling edge, returns at a falling edge
  task automatic send_word(logic [KIND_W-1:0] kind, logic [ID_W-1:0] a,
                           logic [ID_W-1:0] b, logic [SLOT_W-1:0] slot);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {1'b0, slot, b, a};
    s_tuser  = kind;
    do @(posedge clk); while (!s_tready);
    shadow.note_word(kind, a, b, slot);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    shadow.set_reg(idx, v);
  endtask

  task automatic drain_results();
    s_tvalid = 1'b0;
    while (shadow.awaited_resps.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // 43 of every 100 ids come from a small hot set so lists actually fill up
  function automatic logic [ID_W-1:0] pick_id(int unsigned live);
    int r;
    r = $urandom_range(0, 99);
    if (live == 0 || r < 12) return ID_W'($urandom_range(0, NODES - 1));
    if (r < 55) return ID_W'($urandom_range(0, ((live < 8) ? live : 8) - 1));
    return ID_W'($urandom_range(0, live - 1));
  endfunction

  task automatic run_random(int count);
    int done;
    int n;
    int r;
    int clear_pct;
    logic [ID_W-1:0] a;
    logic [ID_W-1:0] b;
    done = 0;
    n    = 0;
    while (done < count) begin
      if (n % 50 == 0) src_steady = ($urandom_range(0, 3) == 0);
      n++;
      r         = $urandom_range(0, 99);
      clear_pct = shadow.err ? 30 : 3;
      a         = pick_id(shadow.live_nodes());
      b         = pick_id(shadow.live_nodes());
      if (r < clear_pct) begin
        send_word(KIND_CLEAR, ID_W'($urandom), ID_W'($urandom), SLOT_W'($urandom));
      end else if (r < clear_pct + 4) begin
        send_word(KIND_SPARE, ID_W'($urandom), ID_W'($urandom), SLOT_W'($urandom));
      end else if (r < 60) begin
        send_word(KIND_INSERT, a, b, SLOT_W'($urandom));
      end else begin
        send_word(KIND_READ, a, ID_W'($urandom), SLOT_W'($urandom));
      end
      done++;
    end
  endtask

  initial begin : result_sink
    int stall;
    int count;
    count       = 0;
    sink_steady = 1'b0;
    m_tready    = 1'b0;
    @(negedge clk);
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      shadow.check_resp(status_t'(m_tuser), m_tdata[VAL_W-1:0]);
      count++;
      if (count % 64 == 0) sink_steady = ($urandom_range(0, 3) == 0);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int nc_list [N_PHASES];
    int sc_list [N_PHASES];
    nc_list = '{2047, 1, 0, 3, 12, 1024, 40, 700, 1024};
    sc_list = '{15, 1, 0, 2, 4, 8, 8, 3, 8};
    shadow       = new();
    src_steady   = 1'b0;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = KIND_CLEAR;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: id extremes, self pair, empty slots, spare kind
    send_word(KIND_CLEAR, '0, '0, '0);
    send_word(KIND_READ, 10'd0, '0, 3'd0);
    send_word(KIND_INSERT, 10'd0, 10'd1023, 3'd7);
    send_word(KIND_INSERT, 10'd5, 10'd5, 3'd0);
    send_word(KIND_READ, 10'd0, '0, 3'd0);
    send_word(KIND_READ, 10'd1023, 10'd1023, 3'd0);
    send_word(KIND_READ, 10'd5, '0, 3'd0);
    send_word(KIND_READ, 10'd5, '0, 3'd1);
    send_word(KIND_READ, 10'd1023, '0, 3'd7);
    send_word(KIND_SPARE, 10'd1023, 10'd1023, 3'd7);
    drain_results();

    // tiny table: full lists, error latch, bad ids
    write_reg(REG_NODE_COUNT, 11'd4);
    write_reg(REG_SLOTS_PER_NODE, 11'd1);
    send_word(KIND_CLEAR, '0, '0, '0);
    send_word(KIND_INSERT, 10'd0, 10'd1, 3'd0);
    send_word(KIND_INSERT, 10'd0, 10'd2, 3'd0);   // first list full
    send_word(KIND_INSERT, 10'd2, 10'd3, 3'd0);   // ignored, error latched
    send_word(KIND_READ, 10'd0, '0, 3'd0);        // reads still served
    send_word(KIND_READ, 10'd4, '0, 3'd0);
    send_word(KIND_CLEAR, '0, '0, '0);
    send_word(KIND_INSERT, 10'd0, 10'd1, 3'd0);
    send_word(KIND_INSERT, 10'd2, 10'd1, 3'd0);   // second list full
    send_word(KIND_CLEAR, '0, '0, '0);
    send_word(KIND_INSERT, 10'd3, 10'd4, 3'd0);
    send_word(KIND_CLEAR, '0, '0, '0);
    send_word(KIND_INSERT, 10'd3, 10'd3, 3'd0);   // self pair fits one slot

    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      write_reg(REG_NODE_COUNT, CFG_W'(nc_list[p]));
      write_reg(REG_SLOTS_PER_NODE, CFG_W'(sc_list[p]));
      // sometimes keep the old table across a settings change
      if ($urandom_range(0, 1) == 0) send_word(KIND_CLEAR, '0, '0, '0);
      run_random(PHASE_WORDS);
    end

    drain_results();
    repeat (16) @(negedge clk);
    if (shadow.awaited_resps.size() != 0) begin
      $error("%0d result words never arrived", shadow.awaited_resps.size());
      shadow.mismatches++;
    end
    if (shadow.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/adj_pkg.sv
rtl/core/adj_ram.sv
rtl/core/adj_unit.sv
rtl/core/adj_ctrl.sv
rtl/core/pair_list_to_adjacency_table.sv
tb/sv/pair_list_to_adjacency_table_tb.sv
